// ----- rtl/sphere_deposition_landing_top_defines.svh -----
// ----------------------------------------------------------------------------
// Sphere deposition landing: assertion macros
// Concurrent check helpers shared by the asserting files.
// ----------------------------------------------------------------------------
`ifndef SPHERE_DEPOSITION_LANDING_TOP_DEFINES_SVH
`define SPHERE_DEPOSITION_LANDING_TOP_DEFINES_SVH

// implication checked in the same cycle
`define SDL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the next cycle
`define SDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sdl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere deposition landing package
// Shared widths, codes and types.
// ----------------------------------------------------------------------------
package sdl_pkg;

   localparam int MAX_SPHERES = 4096;
   localparam int FRAC_BITS   = 12;
   localparam int IDX_W       = $clog2(MAX_SPHERES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int POS_W       = 20;
   localparam int RAD_W       = 16;
   localparam int HGT_W       = 22;
   localparam int CELL_W      = 8;
   localparam int RS_W        = RAD_W + 1;
   localparam int PROD_W      = 2 * POS_W;
   localparam int D2_W        = PROD_W + 1;
   localparam int RADICAND_W  = 2 * RS_W;
   localparam int ROOT_W      = RS_W;
   localparam int HACC_W      = HGT_W + 1;
   localparam int CSR_IDX_W   = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_X       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_Y       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT_LIMIT = 2'd2;

   localparam logic [CELL_W-1:0] GRID_X_RESET       = 8'd64;
   localparam logic [CELL_W-1:0] GRID_Y_RESET       = 8'd64;
   localparam logic [HGT_W-1:0]  HEIGHT_LIMIT_RESET = 22'd262144;

   typedef enum logic [1:0] {
      ST_PLACED  = 2'd0,
      ST_OUTSIDE = 2'd1,
      ST_ABOVE   = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD,
      S_MX,
      S_MY,
      S_MR,
      S_CMP,
      S_SQ,
      S_ACC,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [HGT_W-1:0] z;
      logic [RAD_W-1:0] r;
   } entry_type;

endpackage

// ----- rtl/sdl_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere deposition landing channels
// Valid/ready channels for drop requests and landing responses.
// ----------------------------------------------------------------------------
interface sdl_req_if;
   import sdl_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] x_pos;
   logic [POS_W-1:0] y_pos;
   logic [RAD_W-1:0] radius;
   modport source (output valid, x_pos, y_pos, radius, input ready);
   modport sink (input valid, x_pos, y_pos, radius, output ready);
endinterface

interface sdl_rsp_if;
   import sdl_pkg::*;
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [HGT_W-1:0] landing_height;
   logic [CNT_W-1:0] placed_count;
   modport source (output valid, status, landing_height, placed_count, input ready);
   modport sink (input valid, status, landing_height, placed_count, output ready);
endinterface

// ----- rtl/sphere_deposition_landing_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere deposition landing top level
// Sequencer, shared multiplier and landing decision for ballistic deposition.
// ----------------------------------------------------------------------------
// One drop is handled at a time. A drop outside the area, or a drop onto an
// empty store, goes from the accept cycle straight to the decision cycle. The
// response is registered and is valid from the cycle after the decision.
// Otherwise every stored sphere is visited in turn. A sphere out of reach
// passes through the read, dx, dy and radius multiply, compare and advance
// states, using the single shared 20x20 multiplier (three products per
// sphere). A sphere in contact also runs the bit-serial square root, which
// forms 17 result bits and then raises done. Up to 4096 spheres are stored.
// A response that is not taken holds the sequencer in its decision cycle.
// The request channel is not ready while a drop is in progress.
// ----------------------------------------------------------------------------
`include "sphere_deposition_landing_top_defines.svh"

module sphere_deposition_landing_top
   import sdl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   sdl_req_if.sink              req_chan,
   sdl_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [HGT_W-1:0]     csr_wr_data
);

   state_type         state_ff, state_in;
   logic [CELL_W-1:0] grid_x_ff, grid_y_ff;
   logic [HGT_W-1:0]  limit_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [POS_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic [RAD_W-1:0]  r_ff, r_in;
   logic              outside_ff, outside_in;
   logic [HACC_W-1:0] h_ff, h_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [D2_W-1:0]   d2_ff, d2_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [HGT_W-1:0]  rsp_height_ff, rsp_height_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [POS_W-1:0]      mul_a, mul_b;
   logic [POS_W-1:0]      dx, dy;
   logic [RS_W-1:0]       rs;
   logic                  sq_start, sq_done;
   logic [RADICAND_W-1:0] sq_rad;
   logic [ROOT_W-1:0]     sq_root;
   logic                  wr_en;
   entry_type             wr_data, rd_data;
   logic [HACC_W-1:0]     cand, h_fin;
   logic                  slot_free;

   sdl_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   sdl_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_x_ff <= GRID_X_RESET;
         grid_y_ff <= GRID_Y_RESET;
         limit_ff  <= HEIGHT_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GRID_X:       grid_x_ff <= csr_wr_data[CELL_W-1:0];
            CSR_GRID_Y:       grid_y_ff <= csr_wr_data[CELL_W-1:0];
            CSR_HEIGHT_LIMIT: limit_ff  <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      dx      = (x_ff >= rd_data.x) ? x_ff - rd_data.x : rd_data.x - x_ff;
      dy      = (y_ff >= rd_data.y) ? y_ff - rd_data.y : rd_data.y - y_ff;
      rs      = {1'b0, r_ff} + {1'b0, rd_data.r};
      cand    = {{(HACC_W-ROOT_W){1'b0}}, sq_root} + {1'b0, rd_data.z};
      h_fin   = (h_ff > {{(HACC_W-RAD_W){1'b0}}, r_ff}) ? h_ff
                                                       : {{(HACC_W-RAD_W){1'b0}}, r_ff};
      slot_free = !rsp_valid_ff || rsp_chan.ready;
      sq_rad  = prod_ff[RADICAND_W-1:0] - d2_ff[RADICAND_W-1:0];
      wr_data = '{x: x_ff, y: y_ff, z: h_fin[HGT_W-1:0], r: r_ff};

      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      r_in          = r_ff;
      outside_in    = outside_ff;
      h_in          = h_ff;
      d2_in         = d2_ff;
      mul_a         = dx;
      mul_b         = dx;
      sq_start      = 1'b0;
      wr_en         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_height_in = rsp_height_ff;
      rsp_count_in  = rsp_count_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               x_in       = req_chan.x_pos;
               y_in       = req_chan.y_pos;
               r_in       = req_chan.radius;
               h_in       = '0;
               idx_in     = '0;
               outside_in = (req_chan.x_pos[POS_W-1:FRAC_BITS] >= grid_x_ff) ||
                            (req_chan.y_pos[POS_W-1:FRAC_BITS] >= grid_y_ff);
               if (outside_in || count_ff == '0) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD:  state_in = S_MX;
         S_MX:  state_in = S_MY;
         S_MY: begin
            mul_a    = dy;
            mul_b    = dy;
            d2_in    = {1'b0, prod_ff};
            state_in = S_MR;
         end
         S_MR: begin
            mul_a    = {{(POS_W-RS_W){1'b0}}, rs};
            mul_b    = {{(POS_W-RS_W){1'b0}}, rs};
            d2_in    = d2_ff + {1'b0, prod_ff};
            state_in = S_CMP;
         end
         S_CMP: begin
            if (d2_ff < {1'b0, prod_ff}) begin
               sq_start = 1'b1;
               state_in = S_SQ;
            end else begin
               state_in = S_ACC;
            end
         end
         S_SQ: begin
            if (sq_done) begin
               if (cand > h_ff) begin
                  h_in = cand;
               end
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            idx_in = idx_ff + 1'b1;
            if ({1'b0, idx_ff} + 1'b1 == count_ff) begin
               state_in = S_FIN;
            end else begin
               state_in = S_RD;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (outside_ff) begin
                  rsp_status_in = ST_OUTSIDE;
                  rsp_height_in = '0;
               end else begin
                  rsp_height_in = h_fin[HGT_W] ? {HGT_W{1'b1}} : h_fin[HGT_W-1:0];
                  if (h_fin > {1'b0, limit_ff}) begin
                     rsp_status_in = ST_ABOVE;
                  end else if (count_ff == CNT_W'(MAX_SPHERES)) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_status_in = ST_PLACED;
                     wr_en         = 1'b1;
                     count_in      = count_ff + 1'b1;
                  end
               end
               rsp_count_in = count_in;
            end
         end
         default: state_in = S_IDLE;
      endcase
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      r_ff          <= r_in;
      outside_ff    <= outside_in;
      h_ff          <= h_in;
      prod_ff       <= prod_in;
      d2_ff         <= d2_in;
      rsp_status_ff <= rsp_status_in;
      rsp_height_ff <= rsp_height_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.landing_height = rsp_height_ff;
   assign rsp_chan.placed_count   = rsp_count_ff;

   `SDL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_SPHERES), "sphere count beyond store depth")
   `SDL_ASSERT_NEXT(a_accept_busy, clock, reset, req_chan.valid && req_chan.ready, state_ff != S_IDLE, "drop accepted but sequencer idle")
   `SDL_ASSERT_NOW(a_write_room, clock, reset, wr_en, count_ff < CNT_W'(MAX_SPHERES) && !outside_ff, "store written without room")

endmodule

// ----- rtl/sdl_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere store
// Single write port, single registered read port memory of landed spheres.
// ----------------------------------------------------------------------------
module sdl_store
   import sdl_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  entry_type        wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_data
);

   entry_type mem [MAX_SPHERES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sdl_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root
// Restoring square root, one result bit per cycle, rounded down.
// ----------------------------------------------------------------------------
module sdl_isqrt
   import sdl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RADICAND_W-1:0] radicand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_SQ_W = $clog2(ROOT_W);
   localparam logic [CNT_SQ_W-1:0] LAST = CNT_SQ_W'(ROOT_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_SQ_W-1:0]   cnt_ff, cnt_in;
   logic [RADICAND_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     res_ff, res_in;
   logic [REM_W-1:0]      rem_sh;
   logic [REM_W-1:0]      trial;

   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RADICAND_W-1 -: 2]};
      trial   = {1'b0, res_ff, 2'b01};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         res_in  = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RADICAND_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            res_in = {res_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            res_in = {res_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign done = done_ff;
   assign root = res_ff;

endmodule
